// ===== hdl/running_latency_mean_std_top_macros.svh =====
// Assertion macros shared by the latency statistics checker.
// No dependencies; the checker file takes this header by include.
`ifndef RUNNING_LATENCY_MEAN_STD_TOP_MACROS_SVH
`define RUNNING_LATENCY_MEAN_STD_TOP_MACROS_SVH

// Clocked property that is ignored while reset is high
`define RLMS_ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is checked during reset as well
`define RLMS_ASSERT_RST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hdl/rlms_pkg.sv =====
// Shared widths, codes and the result beat layout of the latency statistics block.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package rlms_pkg;

   localparam int TICK_W     = 32;
   localparam int MEAN_W     = 40;
   localparam int STD_W      = 40;
   localparam int CNT_OUT_W  = 16;
   localparam int SUM_W      = 64;
   localparam int REQ_DATA_W = 2 * TICK_W;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = MEAN_W + STD_W + CNT_OUT_W;

   // Action codes carried in the request tuser
   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Result beat, mean in the lowest bits
   typedef struct packed {
      logic [CNT_OUT_W-1:0] sample_count;
      logic [STD_W-1:0]     std_ticks;
      logic [MEAN_W-1:0]    mean_ticks;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hdl/running_latency_mean_std_top.sv =====
// Running latency mean and standard deviation by Welford's update.
// Depends on rlms_pkg; one shared compare-subtract unit serves both divides and the root.
//
// Usage:
//   req channel: one beat per probe. tuser bit 0 selects the action (add or clear),
//   tdata carries the receive and send timestamps. req_tready is high only while
//   the sequencer is idle.
//   rsp channel: one beat per request with mean, deviation and count.
//   The two restoring divides (by the count) and the bit-pair square root run on
//   the shared subtractor, the deviation product on a shift-add multiplier, one
//   bit per cycle each. A clear, and an add that wraps the count, go from idle
//   straight to the done state. A new request is taken only once the previous
//   one is finished, but it may be taken while the previous result still sits in
//   the output register.
//   Reset clears all statistics and drops any pending result. When the receiver
//   stalls, the result is held; a finished item after it waits until the held
//   beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module running_latency_mean_std_top
   import rlms_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [REQ_DATA_W-1:0] req_tdata,   // now_ticks[31:0], sent_ticks[63:32]
   input  wire  [REQ_USER_W-1:0] req_tuser,   // action[0]
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // mean[39:0], std[79:40], count[95:80]
);

   localparam int MW     = SAMPLE_BITS + FRAC_BITS;
   localparam int PW     = 2 * MW;
   localparam int PXW    = (PW > FRAC_BITS + SUM_W) ? PW : FRAC_BITS + SUM_W + 1;
   localparam int SQ_RAW = SUM_W + FRAC_BITS;
   localparam int SQ_T   = SQ_RAW + (SQ_RAW % 2);
   localparam int RTW    = SQ_T / 2;
   localparam int SW     = (COUNT_BITS + 1 > RTW + 3) ? COUNT_BITS + 1 : RTW + 3;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIFF = 4'd1;
   localparam logic [3:0] S_DIV1 = 4'd2;
   localparam logic [3:0] S_MEAN = 4'd3;
   localparam logic [3:0] S_ERR  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_DIV2 = 4'd7;
   localparam logic [3:0] S_SQLD = 4'd8;
   localparam logic [3:0] S_SQRT = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [MW-1:0]         mean_ff, mean_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RTW-1:0]        std_ff, std_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]         xs_ff, xs_in;
   logic [MW-1:0]         d_ff, d_in;
   logic                  up_ff, up_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [SW-1:0]         rem_ff, rem_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [SQ_T-1:0]       sq_src_ff, sq_src_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [TICK_W:0]       tick_diff;
   logic                  sample_over;
   logic [SAMPLE_BITS-1:0] sample;
   logic [MW-1:0]         xs_new;
   logic [COUNT_BITS-1:0] count_inc;
   logic [MW:0]           up_sub;
   logic [MW-1:0]         dn_sub;
   logic [MW-1:0]         d_cur;
   logic [MW-1:0]         err;
   logic [MW:0]           mul_sum;
   logic [PXW-1:0]        prod_ext;
   logic                  term_over;
   logic [SUM_W-1:0]      term;
   logic [SUM_W:0]        sum_add;
   logic [SUM_W-1:0]      sum_new;
   logic [SW-1:0]         su_a, su_b;
   logic [SW:0]           su_diff;
   logic                  su_ge;

   // Sample: clamp negative latency to zero, saturate long latency
   assign tick_diff   = {1'b0, req_tdata[TICK_W-1:0]} - {1'b0, req_tdata[2*TICK_W-1:TICK_W]};
   assign sample_over = (tick_diff[TICK_W-1:0] >> SAMPLE_BITS) != '0;
   assign sample      = tick_diff[TICK_W] ? '0 :
                        (sample_over ? '1 : tick_diff[SAMPLE_BITS-1:0]);
   assign xs_new      = MW'(sample) << FRAC_BITS;
   assign count_inc   = count_ff + COUNT_BITS'(1);

   // Distance of the sample from the old mean, and from the new mean
   assign up_sub = {1'b0, xs_ff} - {1'b0, mean_ff};
   assign dn_sub = mean_ff - xs_ff;
   assign d_cur  = up_sub[MW] ? dn_sub : up_sub[MW-1:0];
   assign err    = up_ff ? (xs_ff - mean_ff) : (mean_ff - xs_ff);

   // Shift-add multiplier step, multiplicand is the old distance
   assign mul_sum = {1'b0, prod_ff[PW-1:MW]} + (prod_ff[0] ? {1'b0, d_ff} : '0);

   // Scale the product down and accumulate with saturation
   assign prod_ext  = PXW'(prod_ff);
   assign term_over = (prod_ext >> (FRAC_BITS + SUM_W)) != '0;
   assign term      = term_over ? '1 : prod_ext[FRAC_BITS +: SUM_W];
   assign sum_add   = {1'b0, sum_ff} + {1'b0, term};
   assign sum_new   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

   // Shared compare-subtract: divide step by the count, or root trial
   always_comb begin
      if (state_ff == S_SQRT) begin
         su_a = {rem_ff[SW-3:0], sq_src_ff[SQ_T-1 -: 2]};
         su_b = SW'({std_ff, 2'b01});
      end else begin
         su_a = {rem_ff[SW-2:0], quo_ff[SUM_W-1]};
         su_b = SW'(count_ff);
      end
   end
   assign su_diff = {1'b0, su_a} - {1'b0, su_b};
   assign su_ge   = ~su_diff[SW];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      std_in       = std_ff;
      xs_in        = xs_ff;
      d_in         = d_ff;
      up_in        = up_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      sq_src_in    = sq_src_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               xs_in = xs_new;
               if (req_tuser[0] == ACT_CLEAR) begin
                  count_in = '0;
                  mean_in  = '0;
                  sum_in   = '0;
                  std_in   = '0;
                  state_in = S_DONE;
               end else if (&count_ff) begin
                  // count wraps: restart from this sample
                  count_in = COUNT_BITS'(1);
                  mean_in  = xs_new;
                  sum_in   = '0;
                  std_in   = '0;
                  state_in = S_DONE;
               end else begin
                  count_in = count_inc;
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            up_in    = ~up_sub[MW];
            d_in     = d_cur;
            quo_in   = SUM_W'(d_cur) << (SUM_W - MW);
            rem_in   = '0;
            step_in  = STEP_W'(MW - 1);
            state_in = S_DIV1;
         end
         S_DIV1, S_DIV2: begin
            quo_in = {quo_ff[SUM_W-2:0], su_ge};
            rem_in = su_ge ? su_diff[SW-1:0] : su_a;
            if (step_ff == '0) begin
               state_in = (state_ff == S_DIV1) ? S_MEAN : S_SQLD;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_MEAN: begin
            mean_in  = up_ff ? (mean_ff + quo_ff[MW-1:0]) : (mean_ff - quo_ff[MW-1:0]);
            state_in = S_ERR;
         end
         S_ERR: begin
            prod_in  = PW'(err);
            step_in  = STEP_W'(MW - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = {mul_sum, prod_ff[MW-1:1]};
            if (step_ff == '0) begin
               state_in = S_ACC;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_ACC: begin
            sum_in   = sum_new;
            quo_in   = sum_new;
            rem_in   = '0;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = S_DIV2;
         end
         S_SQLD: begin
            sq_src_in = SQ_T'(quo_ff) << FRAC_BITS;
            rem_in    = '0;
            std_in    = '0;
            step_in   = STEP_W'(RTW - 1);
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            sq_src_in = sq_src_ff << 2;
            rem_in    = su_ge ? su_diff[SW-1:0] : su_a;
            std_in    = {std_ff[RTW-2:0], su_ge};
            if (step_ff == '0) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_DONE: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.mean_ticks   = MEAN_W'(mean_ff);
               rsp_in.std_ticks    = STD_W'(std_ff);
               rsp_in.sample_count = CNT_OUT_W'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         std_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         std_ff       <= std_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      xs_ff     <= xs_in;
      d_ff      <= d_in;
      up_ff     <= up_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      prod_ff   <= prod_in;
      sq_src_ff <= sq_src_in;
      rsp_ff    <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/rlms_checker.sv =====
// Port-level checker for the latency statistics block, bound to the top level.
// Depends on rlms_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "running_latency_mean_std_top_macros.svh"

module rlms_checker
   import rlms_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_tvalid,
   input wire                  req_tready,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire [RSP_DATA_W-1:0] rsp_tdata   // mean[39:0], std[79:40], count[95:80]
);

   logic [1:0] pend_ff, pend_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid & req_tready;
   assign rsp_beat = rsp_tvalid & rsp_tready;

   // Track requests whose result beat has not been taken yet
   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `RLMS_ASSERT_CLK(a_no_spurious_rsp, clock, reset, rsp_tvalid |-> (pend_ff != 2'd0), "result beat without request")
   `RLMS_ASSERT_CLK(a_one_in_work, clock, reset, req_tready |-> (pend_ff <= 2'd1), "ready with two results owed")
   `RLMS_ASSERT_RST(a_reset_idle, clock, reset |=> (req_tready && !rsp_tvalid), "not idle after reset")
   `RLMS_ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result beat changed")

endmodule

bind running_latency_mean_std_top rlms_checker u_rlms_checker (.*);

`default_nettype wire
